// ===== rtl/multirotor_pd_thrust_moment_top_defines.svh =====
// Assertion macros shared by the multirotor PD controller checkers
`ifndef MULTIROTOR_PD_THRUST_MOMENT_TOP_DEFINES_SVH
`define MULTIROTOR_PD_THRUST_MOMENT_TOP_DEFINES_SVH

// Clocked check, quiet while reset is asserted
`define MPD_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define MPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mpd_pkg.sv =====
// Package: constants, types and helper functions for the multirotor PD controller
`timescale 1ns / 1ps
package mpd_pkg;

    // Fixed-point format of every port
    localparam int FRAC_BITS        = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    // CORDIC angle format
    localparam int ANG_FRAC         = 30;
    localparam int ANG_SHIFT        = ANG_FRAC - FRAC_BITS;
    localparam int CW               = 33;   // CORDIC x/y/z width
    localparam int SC_W             = 19;   // sine/cosine width, Q16
    localparam int RE_W             = 20;   // body z column width, Q16

    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    // pi/3 in Q16, the tilt command limit
    localparam logic signed [17:0] TILT_LIM = 18'sd68629;
    localparam logic signed [32:0] ONE_Q    = 33'sd1 <<< FRAC_BITS;

    // Register indices
    localparam logic [2:0] CFG_GAIN_POS      = 3'd0;
    localparam logic [2:0] CFG_GAIN_VEL      = 3'd1;
    localparam logic [2:0] CFG_GAIN_ATT      = 3'd2;
    localparam logic [2:0] CFG_GAIN_RATE     = 3'd3;
    localparam logic [2:0] CFG_GAIN_TILT_POS = 3'd4;
    localparam logic [2:0] CFG_GAIN_TILT_VEL = 3'd5;
    localparam logic [2:0] CFG_WEIGHT_FORCE  = 3'd6;

    // Register reset values
    localparam logic [30:0] RST_GAIN_POS      = 31'd6553600;
    localparam logic [30:0] RST_GAIN_VEL      = 31'd6553600;
    localparam logic [30:0] RST_GAIN_ATT      = 31'd327680;
    localparam logic [30:0] RST_GAIN_RATE     = 31'd163840;
    localparam logic [30:0] RST_GAIN_TILT_POS = 31'd62259;
    localparam logic [30:0] RST_GAIN_TILT_VEL = 31'd117965;
    localparam logic [30:0] RST_WEIGHT_FORCE  = 31'd642253;

    typedef struct packed {
        logic [30:0] pos;
        logic [30:0] vel;
        logic [30:0] att;
        logic [30:0] rate;
        logic [30:0] tilt_pos;
        logic [30:0] tilt_vel;
        logic [30:0] weight;
    } gains_t;

    typedef struct packed {
        logic signed [SC_W-1:0] sin_v;
        logic signed [SC_W-1:0] cos_v;
    } sincos_t;

    // Saturate to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Arctangent of 2^-k in Q30
    function automatic logic [31:0] atan_q30(input int k);
        logic [31:0] r;
        case (k)
            0:  r = 32'h3243F6A8;
            1:  r = 32'h1DAC6705;
            2:  r = 32'h0FADBAFC;
            3:  r = 32'h07F56EA6;
            4:  r = 32'h03FEAB76;
            5:  r = 32'h01FFD55B;
            6:  r = 32'h00FFFAAA;
            7:  r = 32'h007FFF55;
            8:  r = 32'h003FFFEA;
            9:  r = 32'h001FFFFD;
            10: r = 32'h000FFFFF;
            11: r = 32'h0007FFFF;
            12: r = 32'h0003FFFF;
            13: r = 32'h0001FFFF;
            14: r = 32'h0000FFFF;
            15: r = 32'h00007FFF;
            16: r = 32'h00003FFF;
            17: r = 32'h00001FFF;
            18: r = 32'h00000FFF;
            19: r = 32'h000007FF;
            20: r = 32'h000003FF;
            21: r = 32'h000001FF;
            22: r = 32'h000000FF;
            23: r = 32'h0000007F;
            24: r = 32'h0000003F;
            25: r = 32'h0000001F;
            26: r = 32'h0000000F;
            27: r = 32'h00000008;
            28: r = 32'h00000004;
            29: r = 32'h00000002;
            30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/mpd_front.sv =====
// Error, gain and moment pipeline: five register stages
`timescale 1ns / 1ps
module mpd_front (
    input  logic                 clk,
    input  mpd_pkg::gains_t      gains,
    input  logic signed [31:0]   pos_x,
    input  logic signed [31:0]   pos_y,
    input  logic signed [31:0]   pos_z,
    input  logic signed [31:0]   vel_x,
    input  logic signed [31:0]   vel_y,
    input  logic signed [31:0]   vel_z,
    input  logic signed [18:0]   roll,
    input  logic signed [18:0]   pitch,
    input  logic signed [18:0]   yaw,
    input  logic signed [31:0]   rate_x,
    input  logic signed [31:0]   rate_y,
    input  logic signed [31:0]   rate_z,
    output logic signed [31:0]   fv_x,
    output logic signed [31:0]   fv_y,
    output logic signed [31:0]   fv_z,
    output logic signed [31:0]   mom_x,
    output logic signed [31:0]   mom_y,
    output logic signed [31:0]   mom_z
);

    logic signed [31:0] pos_a [3];
    logic signed [31:0] vel_a [3];
    logic signed [18:0] att_a [3];
    logic signed [31:0] rate_a [3];

    logic signed [31:0] g_pos, g_vel, g_att, g_rate, g_tp, g_tv;

    // stage 1: errors
    logic signed [31:0] s1_ex_next [3], s1_ex_reg [3];
    logic signed [31:0] s1_ev_next [3], s1_ev_reg [3];
    logic signed [18:0] s1_att_reg [3];
    logic signed [31:0] s1_w_reg [3];
    // stage 2: gain products
    logic signed [63:0] s2_fp_next [3], s2_fp_reg [3];
    logic signed [63:0] s2_fv_next [3], s2_fv_reg [3];
    logic signed [63:0] s2_rp_next [3], s2_rp_reg [3];
    logic signed [63:0] s2_tp_next [2], s2_tp_reg [2];
    logic signed [63:0] s2_tv_next [2], s2_tv_reg [2];
    logic signed [18:0] s2_att_reg [3];
    // stage 3: tilt command, force vector, rate term
    logic signed [17:0] s3_rd_next [2], s3_rd_reg [2];
    logic signed [31:0] s3_fv_next [3], s3_fv_reg [3];
    logic signed [47:0] s3_rt_next [3], s3_rt_reg [3];
    logic signed [18:0] s3_att_reg [3];
    // stage 4: attitude product
    logic signed [51:0] s4_pa_next [3], s4_pa_reg [3];
    logic signed [47:0] s4_rt_reg [3];
    logic signed [31:0] s4_fv_reg [3];
    // stage 5: moment
    logic signed [31:0] s5_mom_next [3], s5_mom_reg [3];
    logic signed [31:0] s5_fv_reg [3];

    assign pos_a  = '{pos_x, pos_y, pos_z};
    assign vel_a  = '{vel_x, vel_y, vel_z};
    assign att_a  = '{roll, pitch, yaw};
    assign rate_a = '{rate_x, rate_y, rate_z};

    assign g_pos  = $signed({1'b0, gains.pos});
    assign g_vel  = $signed({1'b0, gains.vel});
    assign g_att  = $signed({1'b0, gains.att});
    assign g_rate = $signed({1'b0, gains.rate});
    assign g_tp   = $signed({1'b0, gains.tilt_pos});
    assign g_tv   = $signed({1'b0, gains.tilt_vel});

    // stage 1: ex = pos - 1, ev = vel - floor(ex/2)
    always_comb
    begin
        logic signed [32:0] e;
        for (int i = 0; i < 3; i++)
        begin
            e = 33'(pos_a[i]) - mpd_pkg::ONE_Q;
            s1_ex_next[i] = mpd_pkg::sat32(64'(e));
            s1_ev_next[i] = mpd_pkg::sat32(64'(vel_a[i]) - 64'(e >>> 1));
        end
    end

    // stage 2: products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_fp_next[i] = s1_ex_reg[i] * g_pos;
            s2_fv_next[i] = s1_ev_reg[i] * g_vel;
            s2_rp_next[i] = s1_w_reg[i] * g_rate;
        end
        // index 0 feeds roll (y errors), index 1 feeds pitch (x errors)
        s2_tp_next[0] = s1_ex_reg[1] * g_tp;
        s2_tv_next[0] = s1_ev_reg[1] * g_tv;
        s2_tp_next[1] = s1_ex_reg[0] * g_tp;
        s2_tv_next[1] = s1_ev_reg[0] * g_tv;
    end

    // stage 3: clamp tilt, sum force terms
    always_comb
    begin
        logic signed [63:0] t;
        logic signed [63:0] f;
        for (int j = 0; j < 2; j++)
        begin
            t = (s2_tp_reg[j] >>> mpd_pkg::FRAC_BITS) + (s2_tv_reg[j] >>> mpd_pkg::FRAC_BITS);
            if (j == 1)
                t = -t;
            if (t < 64'(-mpd_pkg::TILT_LIM))
                t = 64'(-mpd_pkg::TILT_LIM);
            else if (t > 64'(mpd_pkg::TILT_LIM))
                t = 64'(mpd_pkg::TILT_LIM);
            s3_rd_next[j] = t[17:0];
        end
        for (int i = 0; i < 3; i++)
        begin
            f = -(s2_fp_reg[i] >>> mpd_pkg::FRAC_BITS) - (s2_fv_reg[i] >>> mpd_pkg::FRAC_BITS);
            if (i == 2)
                f = f + $signed({33'd0, gains.weight});
            s3_fv_next[i] = mpd_pkg::sat32(f);
            s3_rt_next[i] = 48'(s2_rp_reg[i] >>> mpd_pkg::FRAC_BITS);
        end
    end

    // stage 4: gain_att * (att - desired), desired yaw is zero
    always_comb
    begin
        logic signed [19:0] d;
        for (int i = 0; i < 3; i++)
        begin
            if (i < 2)
                d = 20'(s3_att_reg[i]) - 20'(s3_rd_reg[i]);
            else
                d = 20'(s3_att_reg[i]);
            s4_pa_next[i] = d * g_att;
        end
    end

    // stage 5: moment
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s5_mom_next[i] = mpd_pkg::sat32(-64'(s4_pa_reg[i] >>> mpd_pkg::FRAC_BITS)
                                            - 64'(s4_rt_reg[i]));
    end

    // pipeline registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_ex_reg[i]  <= s1_ex_next[i];
            s1_ev_reg[i]  <= s1_ev_next[i];
            s1_att_reg[i] <= att_a[i];
            s1_w_reg[i]   <= rate_a[i];
            s2_fp_reg[i]  <= s2_fp_next[i];
            s2_fv_reg[i]  <= s2_fv_next[i];
            s2_rp_reg[i]  <= s2_rp_next[i];
            s2_att_reg[i] <= s1_att_reg[i];
            s3_fv_reg[i]  <= s3_fv_next[i];
            s3_rt_reg[i]  <= s3_rt_next[i];
            s3_att_reg[i] <= s2_att_reg[i];
            s4_pa_reg[i]  <= s4_pa_next[i];
            s4_rt_reg[i]  <= s3_rt_reg[i];
            s4_fv_reg[i]  <= s3_fv_reg[i];
            s5_mom_reg[i] <= s5_mom_next[i];
            s5_fv_reg[i]  <= s4_fv_reg[i];
        end
        for (int j = 0; j < 2; j++)
        begin
            s2_tp_reg[j] <= s2_tp_next[j];
            s2_tv_reg[j] <= s2_tv_next[j];
            s3_rd_reg[j] <= s3_rd_next[j];
        end
    end

    assign fv_x  = s5_fv_reg[0];
    assign fv_y  = s5_fv_reg[1];
    assign fv_z  = s5_fv_reg[2];
    assign mom_x = s5_mom_reg[0];
    assign mom_y = s5_mom_reg[1];
    assign mom_z = s5_mom_reg[2];

endmodule

// ===== rtl/mpd_cordic.sv =====
// Pipelined CORDIC sine/cosine: range reduction, one stage per iteration, output stage
`timescale 1ns / 1ps
module mpd_cordic #(
    parameter int CORDIC_STEPS = mpd_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [18:0] ang,
    output logic               out_valid,
    output mpd_pkg::sincos_t   sc
);

    localparam int CW = mpd_pkg::CW;

    logic signed [CW-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0] z_reg [CORDIC_STEPS+1];
    logic                 neg_reg [CORDIC_STEPS+1];
    logic                 v_reg [CORDIC_STEPS+1];

    logic signed [CW-1:0] z0_next;
    logic                 neg0_next;
    mpd_pkg::sincos_t     sc_next, sc_reg;
    logic                 out_v_reg;

    // reduce to (-pi, pi], then fold into +-pi/2
    always_comb
    begin
        logic signed [34:0] z_in;
        logic signed [34:0] z_a;
        logic signed [34:0] z_b;
        z_in = 35'(ang) <<< mpd_pkg::ANG_SHIFT;
        if (z_in > mpd_pkg::PI_Q30)
            z_a = z_in - mpd_pkg::TWO_PI_Q30;
        else if (z_in <= -mpd_pkg::PI_Q30)
            z_a = z_in + mpd_pkg::TWO_PI_Q30;
        else
            z_a = z_in;
        neg0_next = 1'b1;
        if (z_a > mpd_pkg::HALF_PI_Q30)
            z_b = z_a - mpd_pkg::PI_Q30;
        else if (z_a < -mpd_pkg::HALF_PI_Q30)
            z_b = z_a + mpd_pkg::PI_Q30;
        else
        begin
            z_b = z_a;
            neg0_next = 1'b0;
        end
        z0_next = z_b[CW-1:0];
    end

    // entry stage
    always_ff @(posedge clk)
    begin
        x_reg[0]   <= mpd_pkg::CORDIC_GAIN_Q30;
        y_reg[0]   <= '0;
        z_reg[0]   <= z0_next;
        neg_reg[0] <= neg0_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    // one rotation per stage
    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_iter
        logic signed [CW-1:0] at;
        assign at = $signed({1'b0, mpd_pkg::atan_q30(k)});

        always_ff @(posedge clk)
        begin
            if (z_reg[k] >= 0)
            begin
                x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                z_reg[k+1] <= z_reg[k] - at;
            end
            else
            begin
                x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                z_reg[k+1] <= z_reg[k] + at;
            end
            neg_reg[k+1] <= neg_reg[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else
                v_reg[k+1] <= v_reg[k];
        end
    end

    // floor to Q16 and undo the fold
    always_comb
    begin
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        xs = x_reg[CORDIC_STEPS] >>> mpd_pkg::ANG_SHIFT;
        ys = y_reg[CORDIC_STEPS] >>> mpd_pkg::ANG_SHIFT;
        if (neg_reg[CORDIC_STEPS])
        begin
            sc_next.cos_v = -xs[mpd_pkg::SC_W-1:0];
            sc_next.sin_v = -ys[mpd_pkg::SC_W-1:0];
        end
        else
        begin
            sc_next.cos_v = xs[mpd_pkg::SC_W-1:0];
            sc_next.sin_v = ys[mpd_pkg::SC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        sc_reg <= sc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else
            out_v_reg <= v_reg[CORDIC_STEPS];
    end

    assign sc        = sc_reg;
    assign out_valid = out_v_reg;

endmodule

// ===== rtl/mpd_thrust.sv =====
// Thrust projection pipeline: body z column, dot product, world force (six stages)
`timescale 1ns / 1ps
module mpd_thrust (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  mpd_pkg::sincos_t   sc_roll,
    input  mpd_pkg::sincos_t   sc_pitch,
    input  logic signed [31:0] fv_x,
    input  logic signed [31:0] fv_y,
    input  logic signed [31:0] fv_z,
    output logic               out_valid,
    output logic signed [31:0] force_x,
    output logic signed [31:0] force_y,
    output logic signed [31:0] force_z
);

    localparam int RE_W = mpd_pkg::RE_W;
    localparam int FB   = mpd_pkg::FRAC_BITS;

    logic signed [31:0] fv_a [3];

    logic signed [37:0] t1_cs_reg, t1_cc_reg;
    logic signed [mpd_pkg::SC_W-1:0] t1_sp_reg;
    logic signed [31:0] t1_fv_reg [3];
    logic signed [RE_W-1:0] t2_re_next [3], t2_re_reg [3];
    logic signed [31:0] t2_fv_reg [3];
    logic signed [51:0] t3_d_next [3], t3_d_reg [3];
    logic signed [RE_W-1:0] t3_re_reg [3];
    logic signed [31:0] t4_f_next, t4_f_reg;
    logic signed [RE_W-1:0] t4_re_reg [3];
    logic signed [51:0] t5_q_next [3], t5_q_reg [3];
    logic signed [31:0] t6_o_next [3], t6_o_reg [3];
    logic [5:0] v_reg;

    assign fv_a = '{fv_x, fv_y, fv_z};

    // stage 2: body z column
    always_comb
    begin
        logic signed [37:0] a;
        logic signed [37:0] b;
        a = t1_cs_reg >>> FB;
        b = t1_cc_reg >>> FB;
        t2_re_next[0] = RE_W'(t1_sp_reg);
        t2_re_next[1] = -a[RE_W-1:0];
        t2_re_next[2] = b[RE_W-1:0];
    end

    // stage 3 and 5 products, stage 4 thrust, stage 6 saturation
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t3_d_next[i] = t2_re_reg[i] * t2_fv_reg[i];
            t5_q_next[i] = t4_re_reg[i] * t4_f_reg;
            t6_o_next[i] = mpd_pkg::sat32(64'(t5_q_reg[i] >>> FB));
        end
        t4_f_next = mpd_pkg::sat32(64'(t3_d_reg[0] >>> FB) + 64'(t3_d_reg[1] >>> FB)
                                   + 64'(t3_d_reg[2] >>> FB));
    end

    always_ff @(posedge clk)
    begin
        t1_cs_reg <= sc_pitch.cos_v * sc_roll.sin_v;
        t1_cc_reg <= sc_pitch.cos_v * sc_roll.cos_v;
        t1_sp_reg <= sc_pitch.sin_v;
        t4_f_reg  <= t4_f_next;
        for (int i = 0; i < 3; i++)
        begin
            t1_fv_reg[i] <= fv_a[i];
            t2_re_reg[i] <= t2_re_next[i];
            t2_fv_reg[i] <= t1_fv_reg[i];
            t3_d_reg[i]  <= t3_d_next[i];
            t3_re_reg[i] <= t2_re_reg[i];
            t4_re_reg[i] <= t3_re_reg[i];
            t5_q_reg[i]  <= t5_q_next[i];
            t6_o_reg[i]  <= t6_o_next[i];
        end
    end

    // valid travels with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[4:0], in_valid};
    end

    assign out_valid = v_reg[5];
    assign force_x   = t6_o_reg[0];
    assign force_y   = t6_o_reg[1];
    assign force_z   = t6_o_reg[2];

endmodule

// ===== rtl/multirotor_pd_thrust_moment_top.sv =====
// Throughput: one state sample per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the CORDIC pipeline (one stage per iteration) plus the six-stage
// thrust projection; the moment path is delayed to line up with it.
// Reset: rst_n clears all valid flags and restores the gain registers to defaults.
`timescale 1ns / 1ps
module multirotor_pd_thrust_moment_top #(
    parameter int CORDIC_STEPS = mpd_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic signed [18:0] roll,
    input  logic signed [18:0] pitch,
    input  logic signed [18:0] yaw,
    input  logic signed [31:0] rate_x,
    input  logic signed [31:0] rate_y,
    input  logic signed [31:0] rate_z,
    output logic               done,
    output logic signed [31:0] force_x,
    output logic signed [31:0] force_y,
    output logic signed [31:0] force_z,
    output logic signed [31:0] moment_x,
    output logic signed [31:0] moment_y,
    output logic signed [31:0] moment_z
);

    // force vector waits for the CORDIC result, moment for the whole thrust path
    localparam int FV_DLY  = CORDIC_STEPS - 3;
    localparam int MOM_DLY = CORDIC_STEPS + 3;

    mpd_pkg::gains_t  gains_reg;
    logic             accept;
    logic signed [31:0] fv_x, fv_y, fv_z, mom_x, mom_y, mom_z;
    logic             sc_roll_v, sc_pitch_v;
    mpd_pkg::sincos_t sc_roll, sc_pitch;
    logic signed [31:0] fv_dly_reg [FV_DLY][3];
    logic signed [31:0] mom_dly_reg [MOM_DLY][3];

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.pos      <= mpd_pkg::RST_GAIN_POS;
            gains_reg.vel      <= mpd_pkg::RST_GAIN_VEL;
            gains_reg.att      <= mpd_pkg::RST_GAIN_ATT;
            gains_reg.rate     <= mpd_pkg::RST_GAIN_RATE;
            gains_reg.tilt_pos <= mpd_pkg::RST_GAIN_TILT_POS;
            gains_reg.tilt_vel <= mpd_pkg::RST_GAIN_TILT_VEL;
            gains_reg.weight   <= mpd_pkg::RST_WEIGHT_FORCE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mpd_pkg::CFG_GAIN_POS:      gains_reg.pos      <= cfg_wdata;
                mpd_pkg::CFG_GAIN_VEL:      gains_reg.vel      <= cfg_wdata;
                mpd_pkg::CFG_GAIN_ATT:      gains_reg.att      <= cfg_wdata;
                mpd_pkg::CFG_GAIN_RATE:     gains_reg.rate     <= cfg_wdata;
                mpd_pkg::CFG_GAIN_TILT_POS: gains_reg.tilt_pos <= cfg_wdata;
                mpd_pkg::CFG_GAIN_TILT_VEL: gains_reg.tilt_vel <= cfg_wdata;
                mpd_pkg::CFG_WEIGHT_FORCE:  gains_reg.weight   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    mpd_front u_front (
        .clk    (clk),
        .gains  (gains_reg),
        .pos_x  (pos_x),
        .pos_y  (pos_y),
        .pos_z  (pos_z),
        .vel_x  (vel_x),
        .vel_y  (vel_y),
        .vel_z  (vel_z),
        .roll   (roll),
        .pitch  (pitch),
        .yaw    (yaw),
        .rate_x (rate_x),
        .rate_y (rate_y),
        .rate_z (rate_z),
        .fv_x   (fv_x),
        .fv_y   (fv_y),
        .fv_z   (fv_z),
        .mom_x  (mom_x),
        .mom_y  (mom_y),
        .mom_z  (mom_z)
    );

    mpd_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .ang       (roll),
        .out_valid (sc_roll_v),
        .sc        (sc_roll)
    );

    mpd_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .ang       (pitch),
        .out_valid (sc_pitch_v),
        .sc        (sc_pitch)
    );

    // alignment delay lines
    always_ff @(posedge clk)
    begin
        fv_dly_reg[0]  <= '{fv_x, fv_y, fv_z};
        mom_dly_reg[0] <= '{mom_x, mom_y, mom_z};
        for (int j = 1; j < FV_DLY; j++)
            fv_dly_reg[j] <= fv_dly_reg[j-1];
        for (int j = 1; j < MOM_DLY; j++)
            mom_dly_reg[j] <= mom_dly_reg[j-1];
    end

    mpd_thrust u_thrust (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sc_roll_v & sc_pitch_v),
        .sc_roll   (sc_roll),
        .sc_pitch  (sc_pitch),
        .fv_x      (fv_dly_reg[FV_DLY-1][0]),
        .fv_y      (fv_dly_reg[FV_DLY-1][1]),
        .fv_z      (fv_dly_reg[FV_DLY-1][2]),
        .out_valid (done),
        .force_x   (force_x),
        .force_y   (force_y),
        .force_z   (force_z)
    );

    assign moment_x = mom_dly_reg[MOM_DLY-1][0];
    assign moment_y = mom_dly_reg[MOM_DLY-1][1];
    assign moment_z = mom_dly_reg[MOM_DLY-1][2];

endmodule

// ===== rtl/mpd_checker.sv =====
// Port-level checker for the multirotor PD controller, bound to the top level
`timescale 1ns / 1ps
`include "multirotor_pd_thrust_moment_top_defines.svh"
module mpd_checker #(
    parameter int CORDIC_STEPS = mpd_pkg::CORDIC_STEPS_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    localparam int LAT = CORDIC_STEPS + 8;

    // every accepted transaction returns its result on done
    `MPD_ASSERT_CLK(a_done_after_start, start && !busy |-> ##LAT done, "result missing")
    // no result without a transaction
    `MPD_ASSERT_CLK(a_done_has_start, done |-> $past(start && !busy, LAT), "spurious result")
    // the pipeline never pushes back
    `MPD_ASSERT_CLK(a_never_busy, !busy, "busy raised")
    // nothing leaves while reset is held
    `MPD_ASSERT_ALWAYS(a_quiet_in_reset, !rst_n |-> !done, "result during reset")

endmodule

bind multirotor_pd_thrust_moment_top mpd_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_mpd_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
